@@ sv/plc_pkg.sv @@
// shared types, codes and constants for the positional list engine
`default_nettype none

package plc_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W = 9;
  localparam int CNT_W = 9;
  localparam int ACT_W = 4;
  localparam int STAT_W = 3;
  localparam int DEFAULT_CAPACITY = 256;

  // command codes
  localparam logic [ACT_W-1:0] ACT_GET        = 4'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 4'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE     = 4'd2;
  localparam logic [ACT_W-1:0] ACT_LOCATE     = 4'd3;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd4;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd7;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // input beat
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } plc_cmd_t;

  // result beat
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         count;
  } plc_res_t;

  // what every cell does with its word this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } plc_cell_op_t;

  // broadcast to the cell row
  typedef struct packed {
    plc_cell_op_t             op;
    logic                     locate;
    logic signed [DATA_W-1:0] value;
  } plc_cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } plc_state_t;

endpackage

`default_nettype wire

@@ sv/plc_cell.sv @@
// one list cell: holds a word, shifts with its neighbors, passes the search result down the row
`default_nettype none

module plc_cell #(
  parameter int CAPACITY = plc_pkg::DEFAULT_CAPACITY,
  parameter int INDEX = 0
) (
  input  wire logic                                   clk,
  input  wire plc_pkg::plc_cell_cmd_t                 cmd,
  input  wire logic [$clog2(CAPACITY)-1:0]            slot,
  input  wire logic [$clog2(CAPACITY+1)-1:0]          len,
  input  wire logic signed [plc_pkg::DATA_W-1:0]      prev_word,
  input  wire logic signed [plc_pkg::DATA_W-1:0]      next_word,
  input  wire logic                                   hit_found_in,
  input  wire logic signed [plc_pkg::DATA_W-1:0]      hit_word_in,
  input  wire logic [$clog2(CAPACITY+1)-1:0]          hit_pos_in,
  output logic signed [plc_pkg::DATA_W-1:0]           word,
  output logic                                        hit_found,
  output logic signed [plc_pkg::DATA_W-1:0]           hit_word,
  output logic [$clog2(CAPACITY+1)-1:0]               hit_pos
);
  import plc_pkg::*;

  localparam int IDXW = $clog2(CAPACITY);
  localparam int LENW = $clog2(CAPACITY+1);
  localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);
  localparam logic [LENW-1:0] MY_LEN_IDX = LENW'(INDEX);
  localparam logic [LENW-1:0] MY_POS = LENW'(INDEX + 1);

  logic signed [DATA_W-1:0] word_next;
  logic                     is_at;
  logic                     is_after;
  logic                     hit;

  assign is_at = (slot == MY_IDX);
  assign is_after = (MY_IDX > slot);

  // shift select
  always_comb begin
    word_next = word;
    case (cmd.op)
      OP_INSERT: begin
        if (is_at) begin
          word_next = cmd.value;
        end else if (is_after) begin
          word_next = prev_word;
        end
      end
      OP_DELETE: begin
        if (is_at || is_after) begin
          word_next = next_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // local match for get or locate
  assign hit = cmd.locate ? ((MY_LEN_IDX < len) && (word == cmd.value)) : is_at;

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // first-match ripple: an upstream hit wins over ours
  always_ff @(posedge clk) begin
    if (hit_found_in) begin
      hit_found <= 1'b1;
      hit_word <= hit_word_in;
      hit_pos <= hit_pos_in;
    end else begin
      hit_found <= hit;
      hit_word <= word;
      hit_pos <= MY_POS;
    end
  end

endmodule

`default_nettype wire

@@ sv/positional_list_engine.sv @@
// top level: command decode, length counter, scan sequencer and the cell row
// A command is taken when start is high and busy is low. Insert, delete, push, pop, clear,
// unknown codes and any command refused for position, fullness or emptiness finish at
// the accepting edge: done pulses for one cycle in the next cycle with the result, busy
// stays low, so such commands can follow one another every clock. A get with a good
// position and every locate run a match down the row of CAPACITY cells one cell per
// clock: busy is high while the scan runs, and done pulses as busy falls.
// done lasts one cycle and cannot be held off, so capture result while done is high;
// count in the result is the list length after the command, kept to its low 9 bits.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = plc_pkg::DEFAULT_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire plc_pkg::plc_cmd_t command,
  output logic                   done,
  output plc_pkg::plc_res_t      result
);
  import plc_pkg::*;

  localparam int IDXW = $clog2(CAPACITY);
  localparam int LENW = $clog2(CAPACITY+1);
  localparam int CW = ((LENW > POS_W) ? LENW : POS_W) + 1;
  localparam logic [LENW-1:0] CAP_LEN = LENW'(CAPACITY);

  plc_state_t state;
  plc_state_t state_next;
  logic [LENW-1:0] cnt;
  logic [LENW-1:0] cnt_next;
  logic [LENW-1:0] len;
  logic [LENW-1:0] len_next;
  logic done_next;
  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] res_status_next;
  logic signed [DATA_W-1:0] res_read;
  logic signed [DATA_W-1:0] res_read_next;
  logic [POS_W-1:0] res_found;
  logic [POS_W-1:0] res_found_next;
  logic scan_locate;
  logic signed [DATA_W-1:0] scan_value;
  logic [IDXW-1:0] scan_slot;
  logic load_scan;

  logic accept;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] len_w;
  logic [CW-1:0] slot_w;
  logic [CW-1:0] hit_pos_w;
  logic [IDXW-1:0] in_slot;
  logic [IDXW-1:0] tail_slot;
  logic pos_zero;
  logic full;
  logic empty;

  plc_cell_cmd_t cell_cmd;
  logic [IDXW-1:0] cell_slot;

  logic signed [DATA_W-1:0] words [CAPACITY];
  logic hf [CAPACITY];
  logic signed [DATA_W-1:0] hw [CAPACITY];
  logic [LENW-1:0] hp [CAPACITY];

  assign accept = start && !busy;
  assign busy = (state == S_SCAN);

  // position checks in a width that holds both position and length
  assign pos_w = CW'(command.position);
  assign len_w = CW'(len);
  assign slot_w = pos_w - CW'(1);
  assign in_slot = slot_w[IDXW-1:0];
  assign tail_slot = len_w[IDXW-1:0];
  assign pos_zero = (command.position == '0);
  assign full = (len >= CAP_LEN);
  assign empty = (len == '0);

  // command decode and scan sequencing
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    len_next = len;
    done_next = 1'b0;
    res_status_next = res_status;
    res_read_next = res_read;
    res_found_next = res_found;
    load_scan = 1'b0;
    cell_cmd.op = OP_HOLD;
    cell_cmd.locate = scan_locate;
    cell_cmd.value = scan_value;
    cell_slot = scan_slot;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          res_status_next = ST_OK;
          res_read_next = '0;
          res_found_next = '0;
          cell_cmd.value = command.value;
          cell_cmd.locate = (command.action == ACT_LOCATE);
          cell_slot = in_slot;
          case (command.action)
            ACT_GET: begin
              if (pos_zero || (pos_w > len_w)) begin
                res_status_next = ST_BADPOS;
              end else begin
                done_next = 1'b0;
                load_scan = 1'b1;
                state_next = S_SCAN;
                cnt_next = '0;
              end
            end
            ACT_INSERT: begin
              if (pos_zero || (pos_w > len_w + CW'(1))) begin
                res_status_next = ST_BADPOS;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else begin
                cell_cmd.op = OP_INSERT;
                len_next = len + LENW'(1);
              end
            end
            ACT_DELETE: begin
              if (pos_zero || (pos_w > len_w)) begin
                res_status_next = ST_BADPOS;
              end else begin
                cell_cmd.op = OP_DELETE;
                len_next = len - LENW'(1);
              end
            end
            ACT_LOCATE: begin
              done_next = 1'b0;
              load_scan = 1'b1;
              state_next = S_SCAN;
              cnt_next = '0;
            end
            ACT_PUSH_FRONT: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                cell_cmd.op = OP_INSERT;
                cell_slot = '0;
                len_next = len + LENW'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                cell_cmd.op = OP_INSERT;
                cell_slot = tail_slot;
                len_next = len + LENW'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cell_cmd.op = OP_DELETE;
                cell_slot = '0;
                len_next = len - LENW'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                len_next = len - LENW'(1);
              end
            end
            ACT_CLEAR: begin
              len_next = '0;
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_next = cnt + LENW'(1);
        // the end of the row is settled once the match has passed every cell
        if (cnt == CAP_LEN) begin
          state_next = S_IDLE;
          done_next = 1'b1;
          if (scan_locate) begin
            res_read_next = '0;
            if (hf[CAPACITY-1]) begin
              res_status_next = ST_OK;
              res_found_next = hit_pos_w[POS_W-1:0];
            end else begin
              res_status_next = ST_NOTFOUND;
              res_found_next = '0;
            end
          end else begin
            res_status_next = ST_OK;
            res_read_next = hw[CAPACITY-1];
            res_found_next = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign hit_pos_w = CW'(hp[CAPACITY-1]);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      len <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      len <= len_next;
      done <= done_next;
    end
  end

  // result and scan operand registers
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_read <= res_read_next;
    res_found <= res_found_next;
    if (load_scan) begin
      scan_locate <= (command.action == ACT_LOCATE);
      scan_value <= command.value;
      scan_slot <= in_slot;
    end
  end

  // result beat; count follows the length register, which moves with done
  assign result.status = res_status;
  assign result.read_value = res_read;
  assign result.found_position = res_found;
  assign result.count = len_w[CNT_W-1:0];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w;
    logic signed [DATA_W-1:0] next_w;
    logic hf_in;
    logic signed [DATA_W-1:0] hw_in;
    logic [LENW-1:0] hp_in;
    if (i == 0) begin : g_head
      assign prev_w = cell_cmd.value;
      assign hf_in = 1'b0;
      assign hw_in = '0;
      assign hp_in = '0;
    end else begin : g_link
      assign prev_w = words[i-1];
      assign hf_in = hf[i-1];
      assign hw_in = hw[i-1];
      assign hp_in = hp[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_w = words[i];
    end else begin : g_mid
      assign next_w = words[i+1];
    end
    plc_cell #(
      .CAPACITY(CAPACITY),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .cmd(cell_cmd),
      .slot(cell_slot),
      .len(len),
      .prev_word(prev_w),
      .next_word(next_w),
      .hit_found_in(hf_in),
      .hit_word_in(hw_in),
      .hit_pos_in(hp_in),
      .word(words[i]),
      .hit_found(hf[i]),
      .hit_word(hw[i]),
      .hit_pos(hp[i])
    );
  end

  // length never passes the cell count
  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= CAP_LEN)
    else $error("list length above capacity");

  // a result beat never overlaps a running scan
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while scanning");

  // commands other than get and locate answer in the next cycle
  a_fast_done: assert property (@(posedge clk) disable iff (rst)
    (accept && !(command.action == ACT_GET || command.action == ACT_LOCATE)) |=> done)
    else $error("update command gave no result beat");

  // a scan starts only from an accepted command
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(accept))
    else $error("scan started without a command");

  // length changes only on an accepted command
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(accept) && !$past(rst)) |-> $stable(len))
    else $error("length changed without a command");

endmodule

`default_nettype wire
